/* hdl/helix_track_momentum_assert.svh */
// ---------------------------------------------------------------------------
// helix_track_momentum assertion macros
// Shared concurrent assertion forms for the track momentum checker
// ---------------------------------------------------------------------------
`ifndef HELIX_TRACK_MOMENTUM_ASSERT_SVH
`define HELIX_TRACK_MOMENTUM_ASSERT_SVH

// property checked only outside reset
`define HTM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define HTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/htm_pkg.sv */
// ---------------------------------------------------------------------------
// htm_pkg
// Types, constants and tables of the helix track momentum pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package htm_pkg;

  // cordic iteration count (12 to 32)
  localparam int ANGLE_ITERATIONS = 20;

  // field widths
  localparam int COORD_W = 24;
  localparam int RAD_W   = 24;
  localparam int SLOPE_W = 21;
  localparam int SCALE_W = 24;
  localparam int MOM_W   = 32;

  // divider: 24 bit |d| followed by 36 zero bits
  localparam int NUM_W     = 24;
  localparam int DIV_CELLS = 60;
  localparam int DEN_W     = 44;
  localparam int PT_W      = 37;
  localparam int PT_LO_W   = 19;
  localparam int PT_HI_W   = PT_W - PT_LO_W;

  // angle constants in q20 radians
  localparam int ACC_W = 23;
  localparam logic [23:0] TWO_PI_Q20  = 24'd6588397;
  localparam logic signed [24:0] PI_Q20      = 25'sd3294199;
  localparam logic signed [24:0] HALF_PI_Q20 = 25'sd1647099;

  // cordic datapath
  localparam int CW = 34;
  localparam int TRIG_W = 28;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [MOM_W-1:0] MAG_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic               fault;
    logic               chg;
    logic [PT_W-1:0]    pt;
    logic [SLOPE_W-1:0] slope_mag;
    logic               slope_neg;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [ACC_W-1:0] acc;
    logic             qneg;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cor_t;

  // arctangent of 2^-i in q30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/helix_track_momentum.sv */
// Path from start to the result: stage 0, stage 1, the divide chain, the range reduction register,
// the cordic chain, trig magnitudes, partial products and the output register, each registered.
// Throughput: one beat per cycle; busy stays low and the receiver cannot stall.
// The length is set by the 60 cell divide chain and the cordic cell row.
// Reset (rst_n low, synchronous) empties the pipeline and clears the scale register scale_r.
// ---------------------------------------------------------------------------
// helix_track_momentum
// Helix phase by pipelined division, sin/cos by cordic, scaled momentum out
// ---------------------------------------------------------------------------
`default_nettype none

module helix_track_momentum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [htm_pkg::SCALE_W-1:0]   cfg_wr_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [htm_pkg::COORD_W-1:0] in_hit_beam_coord,
  input  wire logic signed [htm_pkg::COORD_W-1:0] in_helix_z_offset,
  input  wire logic signed [htm_pkg::RAD_W-1:0]   in_helix_radius,
  input  wire logic signed [htm_pkg::SLOPE_W-1:0] in_helix_slope,
  input  wire logic                          in_charge_negative,
  output logic                               out_valid,
  output logic signed [htm_pkg::MOM_W-1:0]   out_mom_x,
  output logic signed [htm_pkg::MOM_W-1:0]   out_mom_y,
  output logic signed [htm_pkg::MOM_W-1:0]   out_mom_z,
  output logic                               out_fault
);
  import htm_pkg::*;

  // configuration register
  logic [SCALE_W-1:0] scale_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // stage 0: magnitudes and signs
  logic signed [COORD_W:0] d_s;
  logic [NUM_W-1:0]   d_mag;
  logic [RAD_W-1:0]   r_mag;
  logic [SLOPE_W-1:0] s_mag;
  always_comb begin
    d_s   = {in_hit_beam_coord[COORD_W-1], in_hit_beam_coord}
          - {in_helix_z_offset[COORD_W-1], in_helix_z_offset};
    d_mag = d_s[COORD_W] ? NUM_W'(-d_s) : NUM_W'(d_s);
    r_mag = in_helix_radius[RAD_W-1] ? RAD_W'(-in_helix_radius) : RAD_W'(in_helix_radius);
    s_mag = in_helix_slope[SLOPE_W-1] ? SLOPE_W'(-in_helix_slope) : SLOPE_W'(in_helix_slope);
  end

  logic               st0_vld_r;
  logic [NUM_W-1:0]   st0_d_r;
  logic [RAD_W-1:0]   st0_r_r;
  logic [SLOPE_W-1:0] st0_s_r;
  logic               st0_sneg_r;
  logic               st0_qneg_r;
  logic               st0_fault_r;
  logic               st0_chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_vld_r <= 1'b0;
    end else begin
      st0_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    st0_d_r     <= d_mag;
    st0_r_r     <= r_mag;
    st0_s_r     <= s_mag;
    st0_sneg_r  <= in_helix_slope[SLOPE_W-1];
    st0_qneg_r  <= d_s[COORD_W] ^ in_helix_radius[RAD_W-1] ^ in_helix_slope[SLOPE_W-1];
    st0_fault_r <= (in_helix_radius == '0) || (in_helix_slope == '0);
    st0_chg_r   <= in_charge_negative;
  end

  // stage 1: divisor and transverse momentum products
  logic [RAD_W+SLOPE_W-1:0] den_full;
  logic [RAD_W+SCALE_W-1:0] pt_full;
  always_comb begin
    den_full = st0_r_r * st0_s_r;
    pt_full  = st0_r_r * scale_r + (RAD_W+SCALE_W)'(512);
  end

  logic  st1_vld_r;
  side_t st1_side_r;
  div_t  st1_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
    end else begin
      st1_vld_r <= st0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    st1_side_r.fault     <= st0_fault_r;
    st1_side_r.chg       <= st0_chg_r;
    st1_side_r.pt        <= pt_full[PT_W+9:10];
    st1_side_r.slope_mag <= st0_s_r;
    st1_side_r.slope_neg <= st0_sneg_r;
    st1_div_r.den        <= den_full[DEN_W-1:0];
    st1_div_r.rem        <= '0;
    st1_div_r.num        <= st0_d_r;
    st1_div_r.acc        <= '0;
    st1_div_r.qneg       <= st0_qneg_r;
  end

  // divide chain
  logic  dv_vld  [DIV_CELLS+1];
  side_t dv_side [DIV_CELLS+1];
  div_t  dv_div  [DIV_CELLS+1];

  assign dv_vld[0]  = st1_vld_r;
  assign dv_side[0] = st1_side_r;
  assign dv_div[0]  = st1_div_r;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    htm_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[k]),
      .side_i (dv_side[k]),
      .div_i  (dv_div[k]),
      .vld_o  (dv_vld[k+1]),
      .side_o (dv_side[k+1]),
      .div_o  (dv_div[k+1])
    );
  end

  // range reduction and quadrant fold
  logic [23:0]        m0;
  logic signed [24:0] ms;
  logic               fold;
  always_comb begin
    m0 = {1'b0, dv_div[DIV_CELLS].acc};
    if (dv_div[DIV_CELLS].qneg && (m0 != '0)) begin
      m0 = TWO_PI_Q20 - m0;
    end
    ms   = signed'({1'b0, m0});
    fold = 1'b0;
    if (ms > PI_Q20) begin
      ms = ms - signed'({1'b0, TWO_PI_Q20});
    end
    priority if (ms > HALF_PI_Q20) begin
      ms   = ms - PI_Q20;
      fold = 1'b1;
    end else if (ms < -HALF_PI_Q20) begin
      ms   = ms + PI_Q20;
      fold = 1'b1;
    end else begin
      fold = 1'b0;
    end
  end

  logic  rd_vld_r;
  side_t rd_side_r;
  cor_t  rd_cor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= dv_vld[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    rd_side_r     <= dv_side[DIV_CELLS];
    rd_cor_r.x    <= CORDIC_GAIN_Q30;
    rd_cor_r.y    <= '0;
    rd_cor_r.z    <= CW'(ms) <<< 10;
    rd_cor_r.flip <= fold;
  end

  // cordic chain
  logic  cr_vld  [ANGLE_ITERATIONS+1];
  side_t cr_side [ANGLE_ITERATIONS+1];
  cor_t  cr_cor  [ANGLE_ITERATIONS+1];

  assign cr_vld[0]  = rd_vld_r;
  assign cr_side[0] = rd_side_r;
  assign cr_cor[0]  = rd_cor_r;

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cor
    htm_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shamt    (5'(i)),
      .atan_val (atan_q30(5'(i))),
      .vld_i    (cr_vld[i]),
      .side_i   (cr_side[i]),
      .cor_i    (cr_cor[i]),
      .vld_o    (cr_vld[i+1]),
      .side_o   (cr_side[i+1]),
      .cor_o    (cr_cor[i+1])
    );
  end

  // trig magnitudes in q24 and their signs
  cor_t                 ce;
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  logic [CW-1:0]        xm;
  logic [CW-1:0]        ym;
  always_comb begin
    ce = cr_cor[ANGLE_ITERATIONS];
    xf = ce.flip ? -ce.x : ce.x;
    yf = ce.flip ? -ce.y : ce.y;
    xm = xf[CW-1] ? CW'(-xf) : CW'(xf);
    ym = yf[CW-1] ? CW'(-yf) : CW'(yf);
  end

  logic              tg_vld_r;
  side_t             tg_side_r;
  logic [TRIG_W-1:0] tg_sq_r;
  logic [TRIG_W-1:0] tg_cq_r;
  logic              tg_yneg_r;
  logic              tg_xneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tg_vld_r <= 1'b0;
    end else begin
      tg_vld_r <= cr_vld[ANGLE_ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    tg_side_r <= cr_side[ANGLE_ITERATIONS];
    tg_sq_r   <= TRIG_W'((ym + CW'(32)) >> 6);
    tg_cq_r   <= TRIG_W'((xm + CW'(32)) >> 6);
    tg_yneg_r <= yf[CW-1];
    tg_xneg_r <= xf[CW-1];
  end

  // partial products of pt split into high and low halves
  logic                        pp_vld_r;
  logic                        pp_fault_r;
  logic                        pp_xs_r;
  logic                        pp_ys_r;
  logic                        pp_zs_r;
  logic [PT_HI_W+TRIG_W-1:0]   pp_hx_r;
  logic [PT_LO_W+TRIG_W-1:0]   pp_lx_r;
  logic [PT_HI_W+TRIG_W-1:0]   pp_hz_r;
  logic [PT_LO_W+TRIG_W-1:0]   pp_lz_r;
  logic [PT_HI_W+SLOPE_W-1:0]  pp_hy_r;
  logic [PT_LO_W+SLOPE_W-1:0]  pp_ly_r;
  logic [PT_HI_W-1:0]          pt_hi;
  logic [PT_LO_W-1:0]          pt_lo;

  assign pt_hi = tg_side_r.pt[PT_W-1:PT_LO_W];
  assign pt_lo = tg_side_r.pt[PT_LO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= tg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_fault_r <= tg_side_r.fault;
    pp_xs_r    <= tg_yneg_r ^ tg_side_r.chg;
    pp_ys_r    <= tg_side_r.slope_neg ^ tg_side_r.chg;
    pp_zs_r    <= tg_xneg_r ^ tg_side_r.chg;
    pp_hx_r    <= pt_hi * tg_sq_r;
    pp_lx_r    <= pt_lo * tg_sq_r;
    pp_hz_r    <= pt_hi * tg_cq_r;
    pp_lz_r    <= pt_lo * tg_cq_r;
    pp_hy_r    <= pt_hi * tg_side_r.slope_mag;
    pp_ly_r    <= pt_lo * tg_side_r.slope_mag;
  end

  // sum, round, saturate and sign
  localparam int SUM_W = PT_W + TRIG_W + 1;

  function automatic logic [MOM_W-1:0] sat_sign(input logic [SUM_W-1:0] mag,
                                                input logic neg);
    logic [MOM_W-1:0] m;
    m = (mag > SUM_W'(MAG_MAX)) ? MAG_MAX : mag[MOM_W-1:0];
    return neg ? MOM_W'(-m) : m;
  endfunction

  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [SUM_W-1:0] sum_z;
  always_comb begin
    sum_x = ((SUM_W'(pp_hx_r) << PT_LO_W) + SUM_W'(pp_lx_r) + (SUM_W'(1) << 25)) >> 26;
    sum_z = ((SUM_W'(pp_hz_r) << PT_LO_W) + SUM_W'(pp_lz_r) + (SUM_W'(1) << 25)) >> 26;
    sum_y = ((SUM_W'(pp_hy_r) << PT_LO_W) + SUM_W'(pp_ly_r) + (SUM_W'(1) << 17)) >> 18;
  end

  logic             out_valid_r;
  logic [MOM_W-1:0] out_x_r;
  logic [MOM_W-1:0] out_y_r;
  logic [MOM_W-1:0] out_z_r;
  logic             out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_fault_r <= pp_fault_r;
    out_x_r     <= pp_fault_r ? '0 : sat_sign(sum_x, pp_xs_r);
    out_y_r     <= pp_fault_r ? '0 : sat_sign(sum_y, pp_ys_r);
    out_z_r     <= pp_fault_r ? '0 : sat_sign(sum_z, pp_zs_r);
  end

  assign out_valid = out_valid_r;
  assign out_mom_x = signed'(out_x_r);
  assign out_mom_y = signed'(out_y_r);
  assign out_mom_z = signed'(out_z_r);
  assign out_fault = out_fault_r;

endmodule

`default_nettype wire

/* hdl/htm_div_cell.sv */
// ---------------------------------------------------------------------------
// htm_div_cell
// One restoring divide step, with the quotient bit folded into a 2*pi modulus
// ---------------------------------------------------------------------------
`default_nettype none

module htm_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  htm_pkg::side_t     side_i,
  input  htm_pkg::div_t      div_i,
  output logic               vld_o,
  output htm_pkg::side_t     side_o,
  output htm_pkg::div_t      div_o
);
  import htm_pkg::*;

  logic               vld_r;
  side_t              side_r;
  div_t               div_r;
  div_t               div_nxt;
  logic [DEN_W:0]     trial;
  logic [DEN_W+1:0]   diff;
  logic               qbit;
  logic [ACC_W:0]     acc2;

  // trial subtract of the divisor
  always_comb begin
    trial = {div_i.rem, div_i.num[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, div_i.den};
    qbit  = ~diff[DEN_W+1];
    acc2  = {div_i.acc, qbit};
    div_nxt      = div_i;
    div_nxt.rem  = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    div_nxt.num  = {div_i.num[NUM_W-2:0], 1'b0};
    // running remainder of the quotient modulo 2*pi
    div_nxt.acc  = (acc2 >= TWO_PI_Q20) ? ACC_W'(acc2 - TWO_PI_Q20) : acc2[ACC_W-1:0];
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    side_r <= side_i;
    div_r  <= div_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign div_o  = div_r;

endmodule

`default_nettype wire

/* hdl/htm_cordic_cell.sv */
// ---------------------------------------------------------------------------
// htm_cordic_cell
// One rotation step of the sine and cosine cordic
// ---------------------------------------------------------------------------
`default_nettype none

module htm_cordic_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [4:0]    shamt,
  input  wire logic [30:0]   atan_val,
  input  wire logic          vld_i,
  input  htm_pkg::side_t     side_i,
  input  htm_pkg::cor_t      cor_i,
  output logic               vld_o,
  output htm_pkg::side_t     side_o,
  output htm_pkg::cor_t      cor_o
);
  import htm_pkg::*;

  logic                 vld_r;
  side_t                side_r;
  cor_t                 cor_r;
  cor_t                 cor_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;

  // rotate towards zero residual angle
  always_comb begin
    dx = cor_i.y >>> shamt;
    dy = cor_i.x >>> shamt;
    at = signed'(CW'(atan_val));
    cor_nxt = cor_i;
    if (!cor_i.z[CW-1]) begin
      cor_nxt.x = cor_i.x - dx;
      cor_nxt.y = cor_i.y + dy;
      cor_nxt.z = cor_i.z - at;
    end else begin
      cor_nxt.x = cor_i.x + dx;
      cor_nxt.y = cor_i.y - dy;
      cor_nxt.z = cor_i.z + at;
    end
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    side_r <= side_i;
    cor_r  <= cor_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign cor_o  = cor_r;

endmodule

`default_nettype wire

/* hdl/htm_checker.sv */
// ---------------------------------------------------------------------------
// htm_checker
// Port level checks of the helix track momentum block, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "helix_track_momentum_assert.svh"

module htm_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        cfg_wr_en,
  input wire logic [htm_pkg::SCALE_W-1:0] cfg_wr_data,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic signed [htm_pkg::COORD_W-1:0] in_hit_beam_coord,
  input wire logic signed [htm_pkg::COORD_W-1:0] in_helix_z_offset,
  input wire logic signed [htm_pkg::RAD_W-1:0]   in_helix_radius,
  input wire logic signed [htm_pkg::SLOPE_W-1:0] in_helix_slope,
  input wire logic                        in_charge_negative,
  input wire logic                        out_valid,
  input wire logic signed [htm_pkg::MOM_W-1:0] out_mom_x,
  input wire logic signed [htm_pkg::MOM_W-1:0] out_mom_y,
  input wire logic signed [htm_pkg::MOM_W-1:0] out_mom_z,
  input wire logic                        out_fault
);
  import htm_pkg::*;

  // pipeline never refuses a beat
  `HTM_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")

  // reset empties the pipeline
  `HTM_ASSERT_ALWAYS(a_reset_flush, clk, !rst_n |=> !out_valid, "beat after reset")

  // fault beats carry zero momentum
  `HTM_ASSERT(a_fault_zero, clk, rst_n,
    (out_valid && out_fault) |-> (out_mom_x == 0 && out_mom_y == 0 && out_mom_z == 0),
    "fault beat with momentum")

  // saturation keeps the range symmetric
  `HTM_ASSERT(a_sat_sym, clk, rst_n,
    out_valid |-> (out_mom_x != 32'sh8000_0000 && out_mom_y != 32'sh8000_0000
                   && out_mom_z != 32'sh8000_0000),
    "most negative code on output")

endmodule

bind helix_track_momentum htm_checker u_htm_checker (.*);

`default_nettype wire
